[rtl/core/amr_pkg.sv]
// ----------------------------------------------------------------------------
// amr_pkg
// Shared types and constants of the peak and RMS level meter.
// ----------------------------------------------------------------------------
`default_nettype none

package amr_pkg;

  // Sample field and accumulator widths
  localparam int SAMPLE_W    = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int LEVEL_W     = 16;
  localparam int WIN_W       = 21;
  localparam int SUM_W       = 52;
  localparam int SQ_W        = 31;
  localparam int MEAN_W      = 32;

  // Window length limits
  localparam int              MAX_WINDOW_LEN = 1920000;
  localparam logic [WIN_W-1:0] WINDOW_RESET  = 21'd48000;

  // Configuration register map (register index from paddr bit 2)
  localparam int        CFG_ADDR_W     = 3;
  localparam int        CFG_DATA_W     = 32;
  localparam logic      REG_WINDOW_LEN = 1'b0;

  // Snapshot queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_LVL_W = 3;

  // Back-end iteration counts
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = MEAN_W / 2;
  localparam int STEP_W     = 6;

  // Closed-window snapshot
  typedef struct packed {
    logic [LEVEL_W-1:0] peak;
    logic [SUM_W-1:0]   sum;
    logic [WIN_W-1:0]   count;
  } amr_snap_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic [Q_LVL_W-1:0] level;
    logic               empty;
  } amr_q_stat_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_EMIT
  } amr_bk_state_t;

endpackage

`default_nettype wire

[rtl/core/amr_if.sv]
// ----------------------------------------------------------------------------
// amr_in_if / amr_out_if
// Valid/ready channels for samples and for meter results.
// ----------------------------------------------------------------------------
`default_nettype none

interface amr_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface amr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] peak_level;
  logic [15:0] rms_level;
  logic [20:0] window_count;

  modport source (output valid, output peak_level, output rms_level,
                  output window_count, input ready);
  modport sink   (input valid, input peak_level, input rms_level,
                  input window_count, output ready);
endinterface

`default_nettype wire

[rtl/core/audio_peak_rms_meter_unit.sv]
// ----------------------------------------------------------------------------
// audio_peak_rms_meter_unit
// Peak and RMS level meter over a programmable window of audio samples.
// ----------------------------------------------------------------------------
// Takes one signed sample per cycle while the snapshot queue has room. Each
// sample enters a two-stage accumulator (magnitude and square, then
// peak/sum/count update); when the count passes window_len the window closes
// and its snapshot goes into a four-entry queue. The back end works on one
// snapshot at a time: it loads it, runs a restoring divider for the mean
// and a square root, then emits the result. Windows of 70 samples or more
// (window_len of 69 or more) never stall the input as long as out_ch takes
// each result; shorter windows, or results held up on out_ch, fill the queue
// and in_ch.ready then drops until a slot frees. window_len is at byte
// address 0 and may only be written while the block is idle.
`default_nettype none

module audio_peak_rms_meter_unit import amr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  amr_in_if.sink                     in_ch,
  amr_out_if.source                  out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [WIN_W-1:0] window_len_r;
  logic             cfg_write;
  logic             push, pop;
  amr_snap_t        push_data, head;
  amr_q_stat_t      q_stat;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WINDOW_RESET;
    end else if (cfg_write) begin
      window_len_r <= pwdata[WIN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_WINDOW_LEN) ? CFG_DATA_W'(window_len_r) : '0;

  amr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .window_len (window_len_r),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  amr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  amr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

[rtl/core/amr_front.sv]
// ----------------------------------------------------------------------------
// amr_front
// Accepts samples, squares them and accumulates peak, sum and count. Pushes
// a snapshot into the queue when the window closes.
// ----------------------------------------------------------------------------
`default_nettype none

module amr_front import amr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  amr_in_if.sink                in_ch,
  input  wire logic [WIN_W-1:0] window_len,
  input  wire amr_q_stat_t      q_stat,
  output logic                  push,
  output amr_snap_t             push_data
);

  localparam int EXT_SHIFT = SAMPLE_W - SAMPLE_BITS;

  logic               s1_valid_r;
  logic [LEVEL_W-1:0] s1_mag_r;
  logic [SQ_W-1:0]    s1_sq_r;

  logic [LEVEL_W-1:0] peak_r, peak_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [WIN_W-1:0]   cnt_r, cnt_nxt;

  logic signed [SAMPLE_W-1:0] sx;
  logic [LEVEL_W-1:0]         mag;
  logic [2*LEVEL_W-1:0]       sq_full;
  logic [WIN_W-1:0]           limit;
  logic                       accept;
  logic                       close;

  // Hold off input unless the queue can take this item's snapshot too
  assign in_ch.ready = (q_stat.level + Q_LVL_W'(s1_valid_r)) < Q_LVL_W'(Q_DEPTH);
  assign accept      = in_ch.valid && in_ch.ready;

  // Sign-extend the used sample bits and take the magnitude
  always_comb begin
    sx      = $signed(in_ch.sample <<< EXT_SHIFT) >>> EXT_SHIFT;
    mag     = sx[SAMPLE_W-1] ? LEVEL_W'(~sx + 1'b1) : LEVEL_W'(sx);
    sq_full = mag * mag;
  end

  // Stage 1: register magnitude and square
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mag_r <= mag;
      s1_sq_r  <= sq_full[SQ_W-1:0];
    end
  end

  // Stage 2: accumulate and check the window
  always_comb begin
    limit     = (window_len > WIN_W'(MAX_WINDOW_LEN)) ? WIN_W'(MAX_WINDOW_LEN) : window_len;
    peak_nxt  = (s1_mag_r > peak_r) ? s1_mag_r : peak_r;
    sum_nxt   = sum_r + SUM_W'(s1_sq_r);
    cnt_nxt   = cnt_r + 1'b1;
    close     = s1_valid_r && (cnt_nxt > limit);
    push      = close;
    push_data = '{peak: peak_nxt, sum: sum_nxt, count: cnt_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else if (close) begin
      peak_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else if (s1_valid_r) begin
      peak_r <= peak_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/amr_queue.sv]
// ----------------------------------------------------------------------------
// amr_queue
// Four-entry snapshot queue between the accumulator and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module amr_queue import amr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire amr_snap_t push_data,
  input  wire logic      pop,
  output amr_snap_t      head,
  output amr_q_stat_t    q_stat
);

  amr_snap_t          slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_LVL_W-1:0] level_r, level_nxt;

  // Advance pointers and level
  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      level_r <= level_nxt;
    end
  end

  // Write the snapshot at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.level = level_r;
  assign q_stat.empty = (level_r == '0);

endmodule

`default_nettype wire

[rtl/core/amr_back.sv]
// ----------------------------------------------------------------------------
// amr_back
// Takes one snapshot at a time: restoring division of the sum by the count,
// one quotient bit a cycle, then a digit-by-digit square root, two radicand
// bits a cycle. The result waits in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module amr_back import amr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire amr_q_stat_t q_stat,
  input  wire amr_snap_t   head,
  output logic             pop,
  amr_out_if.source        out_ch
);

  amr_bk_state_t state_r, state_nxt;

  logic [STEP_W-1:0]  step_r;
  logic [LEVEL_W-1:0] peak_r;
  logic [WIN_W-1:0]   div_r;
  logic [SUM_W-1:0]   quo_r;
  logic [WIN_W-1:0]   rem_r;
  logic [MEAN_W-1:0]  rad_r;
  logic [LEVEL_W-1:0] root_r;
  logic [LEVEL_W:0]   srem_r;

  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_peak_r, out_rms_r;
  logic [WIN_W-1:0]   out_cnt_r;

  logic [WIN_W:0]     rem_sh;
  logic               q_bit;
  logic [WIN_W:0]     rem_diff;
  logic [LEVEL_W+2:0] work;
  logic [LEVEL_W+2:0] trial;
  logic               r_bit;
  logic               div_last, sqrt_last, emit;

  // Divider step
  always_comb begin
    rem_sh   = {rem_r, quo_r[SUM_W-1]};
    q_bit    = rem_sh >= {1'b0, div_r};
    rem_diff = rem_sh - {1'b0, div_r};
  end

  // Square-root step
  always_comb begin
    work  = {srem_r, rad_r[MEAN_W-1 -: 2]};
    trial = {1'b0, root_r, 2'b01};
    r_bit = work >= trial;
  end

  // Next state and handshakes
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    emit      = 1'b0;
    div_last  = (step_r == STEP_W'(DIV_STEPS - 1));
    sqrt_last = (step_r == STEP_W'(SQRT_STEPS - 1));
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_last) begin
          state_nxt = BK_SQRT;
        end
      end
      BK_SQRT: begin
        if (sqrt_last) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          emit      = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (pop) begin
          peak_r <= head.peak;
          div_r  <= head.count;
          quo_r  <= head.sum;
          rem_r  <= '0;
          step_r <= '0;
        end
      end
      BK_DIV: begin
        quo_r  <= {quo_r[SUM_W-2:0], q_bit};
        rem_r  <= q_bit ? rem_diff[WIN_W-1:0] : rem_sh[WIN_W-1:0];
        step_r <= div_last ? '0 : step_r + 1'b1;
        if (div_last) begin
          rad_r  <= {quo_r[MEAN_W-2:0], q_bit};
          root_r <= '0;
          srem_r <= '0;
        end
      end
      BK_SQRT: begin
        rad_r  <= {rad_r[MEAN_W-3:0], 2'b00};
        root_r <= {root_r[LEVEL_W-2:0], r_bit};
        srem_r <= r_bit ? (LEVEL_W+1)'(work - trial) : (LEVEL_W+1)'(work);
        step_r <= step_r + 1'b1;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_peak_r <= peak_r;
      out_rms_r  <= root_r;
      out_cnt_r  <= div_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.peak_level   = out_peak_r;
  assign out_ch.rms_level    = out_rms_r;
  assign out_ch.window_count = out_cnt_r;

endmodule

`default_nettype wire

[rtl/core/amr_checker.sv]
// ----------------------------------------------------------------------------
// amr_checker
// Port-level checks of the level meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module amr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] peak_level,
  input wire logic [15:0] rms_level,
  input wire logic [20:0] window_count
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(rms_level) &&
      $stable(peak_level) && $stable(window_count))
    else $error("result changed while stalled");

  // RMS never exceeds the peak of the same window
  a_rms_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> rms_level <= peak_level)
    else $error("rms above peak");

  // Peak stays within full scale and windows are never empty
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (peak_level <= 16'd32768) && (window_count != 21'd0))
    else $error("result out of range");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind audio_peak_rms_meter_unit amr_checker u_amr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .peak_level   (out_ch.peak_level),
  .rms_level    (out_ch.rms_level),
  .window_count (out_ch.window_count)
);

`default_nettype wire

[tb/sv/tb_audio_peak_rms_meter_unit.sv]
// ----------------------------------------------------------------------------
// tb_audio_peak_rms_meter_unit
// Self-checking bench for the peak and RMS level meter.
// ----------------------------------------------------------------------------
// Samples go in on the input channel. Each accepted sample also runs through
// a bench-side level calculator, which queues the peak/RMS/count result that
// the meter must emit when the window closes. Results on the output channel
// are checked against that queue in order. A short table of hand-picked
// samples comes first (one-sample windows where the result is obvious,
// full-scale values, a window shortened while open). Random phases follow,
// each with its own window length written over the register port while
// the meter is drained. Channels stall at random in most phases, not at the end.

module tb_audio_peak_rms_meter_unit;
  import amr_pkg::*;

  localparam int BACKEND_SETTLE = 100;
  localparam int SAMPLE_TARGET  = 1250;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [CFG_ADDR_W-1:0] WINDOW_LEN_ADDR = {REG_WINDOW_LEN, 2'b00};

  typedef struct packed {
    logic [LEVEL_W-1:0] peak;
    logic [LEVEL_W-1:0] rms;
    logic [WIN_W-1:0]   count;
  } level_res_t;

  // One row of the hand-written sample table
  typedef struct packed {
    logic               set_win;
    logic [WIN_W-1:0]   win;
    logic [15:0]        sample;
    logic               fixed_res;
    level_res_t         res;
  } sample_row_t;

  localparam int N_ROWS = 20;

  localparam sample_row_t SAMPLE_ROWS [N_ROWS] = '{
    // open a window at the reset length
    '{1'b0, 21'd0, 16'h7FFF, 1'b0, '0},
    '{1'b0, 21'd0, 16'h8000, 1'b0, '0},
    '{1'b0, 21'd0, 16'h1234, 1'b0, '0},
    // shorten it to zero: the next sample closes a four-sample window
    '{1'b1, 21'd0, 16'hFFFB, 1'b0, '0},
    // one-sample windows: peak and RMS equal the magnitude
    '{1'b0, 21'd0, 16'h7FFF, 1'b1, '{16'd32767, 16'd32767, 21'd1}},
    '{1'b0, 21'd0, 16'h8000, 1'b1, '{16'd32768, 16'd32768, 21'd1}},
    '{1'b0, 21'd0, 16'h0000, 1'b1, '{16'd0,     16'd0,     21'd1}},
    '{1'b0, 21'd0, 16'h0001, 1'b1, '{16'd1,     16'd1,     21'd1}},
    '{1'b0, 21'd0, 16'hFFFF, 1'b1, '{16'd1,     16'd1,     21'd1}},
    '{1'b0, 21'd0, 16'h5555, 1'b1, '{16'd21845, 16'd21845, 21'd1}},
    '{1'b0, 21'd0, 16'hAAAA, 1'b1, '{16'd21846, 16'd21846, 21'd1}},
    '{1'b0, 21'd0, 16'h8001, 1'b1, '{16'd32767, 16'd32767, 21'd1}},
    // two-sample window with mixed signs
    '{1'b1, 21'd1, 16'h0003, 1'b0, '0},
    '{1'b0, 21'd1, 16'hFFFC, 1'b0, '0},
    // three-sample windows at negative and positive full scale
    '{1'b1, 21'd2, 16'h8000, 1'b0, '0},
    '{1'b0, 21'd2, 16'h8000, 1'b0, '0},
    '{1'b0, 21'd2, 16'h8000, 1'b1, '{16'd32768, 16'd32768, 21'd3}},
    '{1'b0, 21'd2, 16'h7FFF, 1'b0, '0},
    '{1'b0, 21'd2, 16'h7FFF, 1'b0, '0},
    '{1'b0, 21'd2, 16'h7FFF, 1'b1, '{16'd32767, 16'd32767, 21'd3}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic sink_ready = 1'b1;
  int   sink_hold = 0;
  bit   stalls_on = 1'b0;

  amr_in_if  in_ch ();
  amr_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  // Bench copy of the meter state
  logic [WIN_W-1:0]   win_len;
  logic [LEVEL_W-1:0] acc_peak;
  logic [SUM_W-1:0]   acc_sum;
  logic [WIN_W-1:0]   acc_count;

  level_res_t pending_levels [$];
  int         fail_count = 0;
  int         samples_sent = 0;

  audio_peak_rms_meter_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Floor square root, one result bit at a time
  function automatic logic [LEVEL_W-1:0] level_isqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root[LEVEL_W-1:0];
  endfunction

  // Add one sample to the window; return 1 and the levels when it closes
  function automatic logic meter_accumulate(input logic signed [15:0] s,
                                            output level_res_t res);
    logic signed [16:0] wide;
    logic [16:0]        mag;
    logic [WIN_W-1:0]   limit;
    logic [63:0]        mean;
    wide  = {s[15], s};
    mag   = (wide < 0) ? 17'(-wide) : 17'(wide);
    limit = (win_len > WIN_W'(MAX_WINDOW_LEN)) ? WIN_W'(MAX_WINDOW_LEN) : win_len;
    res   = '0;
    if (mag[LEVEL_W-1:0] > acc_peak) acc_peak = mag[LEVEL_W-1:0];
    acc_sum   = SUM_W'(64'(acc_sum) + 64'(mag) * 64'(mag));
    acc_count = acc_count + 1'b1;
    if (acc_count <= limit || acc_count == '0) return 1'b0;
    mean      = 64'(acc_sum) / 64'(acc_count);
    res.peak  = acc_peak;
    res.rms   = level_isqrt(mean);
    res.count = acc_count;
    acc_peak  = '0;
    acc_sum   = '0;
    acc_count = '0;
    return 1'b1;
  endfunction

  // Mostly full-range values, with extremes and small magnitudes mixed in
  function automatic logic [15:0] pick_sample();
    logic [15:0] small_mag;
    small_mag = 16'($urandom_range(0, 31));
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return ($urandom_range(0, 1) != 0) ? small_mag : -small_mag;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one sample, hold it until accepted, then predict its result
  task automatic push_sample(input logic [15:0] s, input logic fixed_res,
                             input level_res_t row_res);
    level_res_t res;
    logic       closed;
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    closed = meter_accumulate(s, res);
    if (fixed_res) pending_levels.push_back(row_res);
    else if (closed) pending_levels.push_back(res);
    samples_sent++;
  endtask

  // Drop valid for a random burst now and then
  task automatic sender_gap();
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Hold the input until every queued result is out and the back end is quiet
  task automatic drain_meter();
    in_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (BACKEND_SETTLE) @(posedge clk);
  endtask

  // Write window_len, junk in the unused upper bits, then read it back
  task automatic write_window(input logic [WIN_W-1:0] win, input logic [10:0] junk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WINDOW_LEN_ADDR;
    pwdata  <= {junk, win};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    win_len = win;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== CFG_DATA_W'(win)) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("window_len readback: expected %0d, got %0h", win, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain, set a window length, then stream random samples
  task automatic run_phase(input logic [WIN_W-1:0] win, input int n_items);
    drain_meter();
    write_window(win, ($urandom_range(0, 1) != 0) ? 11'($urandom) : 11'd0);
    repeat (n_items) begin
      sender_gap();
      push_sample(pick_sample(), 1'b0, '0);
    end
  endtask

  // Receiver stalls in bursts of random length
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold  <= sink_hold - 1;
      sink_ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      sink_hold  <= $urandom_range(0, 4);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Check every emitted result against the oldest prediction
  always @(posedge clk) begin
    level_res_t got;
    level_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.peak_level, out_ch.rms_level, out_ch.window_count};
      if (pending_levels.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: peak %0d rms %0d count %0d",
                   got.peak, got.rms, got.count);
      end else begin
        want = pending_levels.pop_front();
        if (got.peak !== want.peak || got.rms !== want.rms || got.count !== want.count)
        begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("result mismatch: expected peak %0d rms %0d count %0d, got %0d %0d %0d",
                     want.peak, want.rms, want.count, got.peak, got.rms, got.count);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int               wait_cycles;
    logic [WIN_W-1:0] win;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    win_len   = WINDOW_RESET;
    acc_peak  = '0;
    acc_sum   = '0;
    acc_count = '0;

    // Synchronous reset, then release
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the sample table
    for (int i = 0; i < N_ROWS; i++) begin
      if (SAMPLE_ROWS[i].set_win) begin
        drain_meter();
        write_window(SAMPLE_ROWS[i].win, 11'd0);
      end
      push_sample(SAMPLE_ROWS[i].sample, SAMPLE_ROWS[i].fixed_res, SAMPLE_ROWS[i].res);
    end

    // Fixed phases: short windows, 257-sample windows, one-sample windows
    stalls_on = 1'b1;
    run_phase(21'd5, 150);
    run_phase(21'd256, 300);
    stalls_on = 1'b0;
    run_phase(21'd0, 40);
    stalls_on = 1'b1;

    // Largest length, then above the maximum, then cut short while open
    run_phase(21'(MAX_WINDOW_LEN), 50);
    run_phase(21'h1FFFFF, 50);
    run_phase(21'd20, 30);

    // Random phases; the last stretch runs without stalls
    while (samples_sent < SAMPLE_TARGET) begin
      if (samples_sent >= SAMPLE_TARGET - 150) stalls_on = 1'b0;
      else stalls_on = ($urandom_range(0, 3) != 0);
      win = ($urandom_range(0, 5) == 0) ? 21'($urandom_range(256, 300))
                                        : 21'($urandom_range(0, 40));
      run_phase(win, $urandom_range(20, 120));
    end

    // Let the last results come out, with a bound
    stalls_on = 1'b0;
    in_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (pending_levels.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (BACKEND_SETTLE) @(posedge clk);
    if (pending_levels.size() != 0) begin
      fail_count++;
      $display("%0d expected results never arrived", pending_levels.size());
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
